FILE: hdl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned NumSlots = 8;  // 3 held bytes, 4 data bytes, 1 terminal
  localparam int unsigned TermSlot = 7;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;

  localparam logic [20:0] Lim1Byte = 21'h00080;
  localparam logic [20:0] Lim2Byte = 21'h00800;
  localparam logic [20:0] Lim3Byte = 21'h10000;
  localparam logic [20:0] SuppBase = 21'h10000;

  // Top six bits of a UTF-16 surrogate code unit
  localparam logic [5:0] HighSurTag = 6'b110110;
  localparam logic [5:0] LowSurTag = 6'b110111;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_UNTERM  = 3'd2,
    ST_BSEND   = 3'd3,
    ST_TRUNC   = 3'd4,
    ST_BADHEX  = 3'd5,
    ST_UNKNOWN = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_PLAIN   = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX     = 3'd2,
    PH_HELD    = 3'd3,
    PH_HELD_BS = 3'd4,
    PH_HEX2    = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } out_t;

  // Results of one input byte, one slot per possible result
  typedef struct packed {
    logic [NumSlots-1:0]        slot_v;
    logic [NumSlots-1:0][7:0]   bytes;
    status_e                    term_st;
  } res_t;

  typedef struct packed {
    logic busy;
    logic last_pop;
  } buf_stat_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  function automatic utf8_t utf8_enc(input logic [20:0] code);
    utf8_t r;
    r.bytes = '0;
    if (code < Lim1Byte) begin
      r.n = 3'd1;
      r.bytes[0] = code[7:0];
    end else if (code < Lim2Byte) begin
      r.n = 3'd2;
      r.bytes[0] = {3'b110, code[10:6]};
      r.bytes[1] = {2'b10, code[5:0]};
    end else if (code < Lim3Byte) begin
      r.n = 3'd3;
      r.bytes[0] = {4'b1110, code[15:12]};
      r.bytes[1] = {2'b10, code[11:6]};
      r.bytes[2] = {2'b10, code[5:0]};
    end else begin
      r.n = 3'd4;
      r.bytes[0] = {5'b11110, code[20:18]};
      r.bytes[1] = {2'b10, code[17:12]};
      r.bytes[2] = {2'b10, code[11:6]};
      r.bytes[3] = {2'b10, code[5:0]};
    end
    return r;
  endfunction

  function automatic esc_t esc_map(input logic [7:0] b);
    esc_t r;
    r.ok = 1'b1;
    case (b)
      ChQuote:  r.val = 8'h22;
      ChBslash: r.val = 8'h5C;
      ChSlash:  r.val = 8'h2F;
      ChLowB:   r.val = 8'h08;
      ChLowF:   r.val = 8'h0C;
      ChLowN:   r.val = 8'h0A;
      ChLowR:   r.val = 8'h0D;
      ChLowT:   r.val = 8'h09;
      default: begin
        r.ok = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic hexd_t hex_digit(input logic [7:0] b);
    hexd_t r;
    r.ok = 1'b1;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.val = b[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
      r.val = 4'd0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/json_string_unescape_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_core
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Accepts the bytes of a JSON string body and returns decoded UTF-8 bytes
// followed by a status result when the string closes or fails. A byte that
// causes n results (0 to 7) sends them in turn through the single output
// port, and the input is stalled until the last of them leaves, so plain
// text runs at one byte per cycle while the output is not stalled. The next
// byte is taken in the same cycle the last result of the previous one
// leaves. Bytes that only advance the escape state produce no result.
module json_string_unescape_core import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic      accept;
  res_t      res;
  buf_stat_t stat;

  // take a new byte once the buffered results are gone or leaving now
  assign in_stall_o = stat.busy & ~stat.last_pop;
  assign accept     = in_valid_i & ~in_stall_o;

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  jsu_resbuf u_resbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .stat_o      (stat)
  );

endmodule

FILE: hdl/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Escape-state registers and the per-byte decode into a result slot set.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  in_data_i,
  output res_t res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hh_q, hh_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        bad_q, bad_d;

  logic [7:0]  b;
  logic        tend;
  esc_t        esc;
  hexd_t       dig;
  logic        bad_n;
  logic [15:0] acc_n;
  logic        held_emit, code_emit, lit_emit, term;
  logic [20:0] code_val;
  logic [7:0]  lit;
  status_e     term_st;
  utf8_t       held_enc, code_enc;
  logic [2:0]  data_n;

  assign b     = in_data_i.in_byte;
  assign tend  = in_data_i.text_end;
  assign esc   = esc_map(b);
  assign dig   = hex_digit(b);
  assign bad_n = bad_q | ~dig.ok;
  assign acc_n = {acc_q[11:0], dig.val};

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    hh_d      = hh_q;
    cnt_d     = cnt_q;
    bad_d     = bad_q;
    held_emit = 1'b0;
    code_emit = 1'b0;
    code_val  = '0;
    lit_emit  = 1'b0;
    lit       = 8'h00;
    term      = 1'b0;
    term_st   = ST_CLOSED;

    case (phase_q)
      PH_ESC, PH_HELD_BS: begin
        if (phase_q == PH_HELD_BS && b == ChLowU) begin
          phase_d = PH_HEX2;
          acc_d = '0;
          cnt_d = '0;
          bad_d = 1'b0;
        end else begin
          held_emit = (phase_q == PH_HELD_BS);
          phase_d = PH_PLAIN;
          if (b == ChLowU) begin
            phase_d = PH_HEX;
            acc_d = '0;
            cnt_d = '0;
            bad_d = 1'b0;
          end else if (esc.ok) begin
            lit_emit = 1'b1;
            lit = esc.val;
          end else begin
            term = 1'b1;
            term_st = ST_UNKNOWN;
          end
        end
      end
      PH_HEX, PH_HEX2: begin
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
          acc_d = acc_n;
          bad_d = bad_n;
        end else if (bad_n) begin
          term = 1'b1;
          term_st = ST_BADHEX;
        end else if (phase_q == PH_HEX2 && acc_n[15:10] == LowSurTag) begin
          code_emit = 1'b1;
          code_val = SuppBase + {1'b0, hh_q, acc_n[9:0]};
          phase_d = PH_PLAIN;
          acc_d = '0;
          cnt_d = '0;
          bad_d = 1'b0;
          hh_d = '0;
        end else begin
          // a non-low second code releases the held high first
          held_emit = (phase_q == PH_HEX2);
          acc_d = '0;
          cnt_d = '0;
          bad_d = 1'b0;
          if (acc_n[15:10] == HighSurTag && !tend) begin
            hh_d = acc_n[9:0];
            phase_d = PH_HELD;
          end else begin
            code_emit = 1'b1;
            code_val = {5'b0, acc_n};
            phase_d = PH_PLAIN;
          end
        end
      end
      default: begin
        held_emit = (phase_q == PH_HELD) && (b != ChBslash);
        if (phase_q == PH_HELD && b == ChBslash) begin
          phase_d = PH_HELD_BS;
        end else if (b == ChQuote) begin
          phase_d = PH_PLAIN;
          term = 1'b1;
          term_st = ST_CLOSED;
        end else if (b == ChBslash) begin
          phase_d = PH_ESC;
        end else begin
          phase_d = PH_PLAIN;
          lit_emit = 1'b1;
          lit = b;
        end
      end
    endcase

    if (!term && tend) begin
      term = 1'b1;
      case (phase_d)
        PH_ESC:         term_st = ST_BSEND;
        PH_HEX, PH_HEX2: term_st = ST_TRUNC;
        PH_HELD_BS: begin
          held_emit = 1'b1;
          term_st = ST_BSEND;
        end
        PH_HELD: begin
          held_emit = 1'b1;
          term_st = ST_UNTERM;
        end
        default:        term_st = ST_UNTERM;
      endcase
    end

    if (term) begin
      phase_d = PH_PLAIN;
      acc_d   = '0;
      hh_d    = '0;
      cnt_d   = '0;
      bad_d   = 1'b0;
    end
  end

  assign held_enc = utf8_enc({5'b0, HighSurTag, hh_q});
  assign code_enc = utf8_enc(code_val);
  assign data_n   = code_emit ? code_enc.n : {2'b00, lit_emit};

  always_comb begin
    res_o.term_st = term_st;
    res_o.bytes   = '0;
    res_o.slot_v  = '0;
    for (int i = 0; i < 3; i++) begin
      res_o.slot_v[i] = held_emit;
      res_o.bytes[i]  = held_enc.bytes[i];
    end
    for (int i = 0; i < 4; i++) begin
      res_o.slot_v[3+i] = (3'(i) < data_n);
      res_o.bytes[3+i]  = code_emit ? code_enc.bytes[i] : ((i == 0) ? lit : 8'h00);
    end
    res_o.slot_v[TermSlot] = term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      acc_q   <= '0;
      hh_q    <= '0;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hh_q    <= hh_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
    end
  end

endmodule

FILE: hdl/jsu_resbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_resbuf
// Result register: holds the slot set of one byte and drains it in order.
// ----------------------------------------------------------------------------
module jsu_resbuf import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_t      res_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_t      out_data_o,
  output buf_stat_t stat_o
);

  logic [NumSlots-1:0]      v_q, v_d;
  logic [NumSlots-1:0][7:0] bytes_q;
  status_e                  st_q;
  logic [NumSlots-1:0]      pick;
  logic [2:0]               sel;
  logic                     last;
  logic                     pop;

  // lowest pending slot goes out first
  assign pick = v_q & (~v_q + 8'd1);

  always_comb begin
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (v_q[i]) sel = 3'(i);
    end
  end

  assign last        = ((v_q & ~pick) == '0);
  assign out_valid_o = |v_q;
  assign pop         = out_valid_o & ~out_stall_i;

  assign out_data_o.out_byte = (sel == 3'(TermSlot)) ? 8'h00 : bytes_q[sel];
  assign out_data_o.status   = (sel == 3'(TermSlot)) ? st_q : ST_DATA;
  assign out_data_o.last     = last;

  assign stat_o.busy     = out_valid_o;
  assign stat_o.last_pop = pop & last;

  always_comb begin
    v_d = v_q;
    if (pop) v_d = v_q & ~pick;
    if (load_i) v_d = res_i.slot_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
      st_q    <= res_i.term_st;
    end
  end

endmodule

FILE: hdl/jsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // results of one byte leave without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a result group");

  // status results end the group and carry a zero byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_DATA |->
      out_data_o.last && out_data_o.out_byte == 8'h00)
    else $error("status result not last or nonzero byte");

  // input stalls only while results are pending
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with nothing to drain");

  // no new byte while a group still has more results
  a_group_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last && in_valid_i |-> in_stall_o)
    else $error("byte accepted mid group");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (.*);
